// ===== src/owvm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package owvm_pkg;

    localparam int WHEELS    = 4;
    localparam int ROW_W     = 48;
    localparam int ROW_IDX_W = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] REQ_MOVE = 2'd0;
    localparam logic [1:0] REQ_SPIN = 2'd1;
    localparam logic [1:0] REQ_STOP = 2'd2;

    localparam int U_W  = 17;
    localparam int TB_W = 14;
    localparam int TA_W = 15;
    localparam int S_W  = 15;
    localparam int C_W  = 11;
    localparam int V_W  = 16;
    localparam int W_W  = 18;

    localparam logic [U_W-1:0]  U_ONE = 17'h1_0000;
    localparam logic [TA_W-1:0] SIN_A = 15'd25736;
    localparam logic [TB_W-1:0] SIN_B = 14'd10512;
    localparam logic [C_W-1:0]  SIN_C = 11'd1160;

    localparam logic signed [W_W-1:0] W_SPIN_POS = 18'sd16384;
    localparam logic signed [W_W-1:0] W_SPIN_NEG = -18'sd16384;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [15:0]        heading;
        logic signed [15:0] rotation;
        logic               spin_ccw;
        logic signed [15:0] speed;
    } t_cmd;

    typedef struct packed {
        logic [7:0] duty_0;
        logic       dir_0;
        logic       brake_0;
        logic [7:0] duty_1;
        logic       dir_1;
        logic       brake_1;
        logic [7:0] duty_2;
        logic       dir_2;
        logic       brake_2;
        logic [7:0] duty_3;
        logic       dir_3;
        logic       brake_3;
    } t_wheel_out;

endpackage

`default_nettype wire

// ===== src/omni_wheel_velocity_mixer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle unless the output stalls; four stages
// of the sine polynomial multiplier chain, then coefficient products, wheel
// sum, speed product, clamp. An output stall freezes the whole pipeline only
// while the output is valid.
// Reset: synchronous active low, clears stage valids and all wheel rows.

module omni_wheel_velocity_mixer_core
    import owvm_pkg::*;
#(
    parameter int COEF_WIDTH  = 16,
    parameter int ANGLE_WIDTH = 16,
    parameter int DUTY_MAX    = 255
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_cmd                 i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_wheel_out                o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ROW_W-1:0]     i_cfg_data
);

    localparam int CW        = COEF_WIDTH;
    localparam int DROP      = (ANGLE_WIDTH < 16) ? (16 - ANGLE_WIDTH) : 0;
    localparam logic [15:0] HEAD_MASK = ~16'((1 << DROP) - 1);
    localparam int ROW_EXT_W = (3 * CW > ROW_W) ? 3 * CW : ROW_W;
    localparam int PW        = CW + 18;
    localparam int VAL_W     = CW + 33;
    localparam int SHIFT     = CW + 12;
    localparam int MAG_W     = VAL_W - SHIFT;
    localparam logic [MAG_W-1:0] DUTY_LIM = MAG_W'(DUTY_MAX);
    localparam logic [15:0]      DUTY_SAT = 16'(DUTY_MAX);

    logic adv;
    logic [7:0] r_vld;
    logic [ROW_W-1:0] r_row [WHEELS];

    // stage 1
    logic [U_W-1:0]     n1_u  [2];
    logic [U_W-1:0]     n1_u2 [2];
    logic [U_W-1:0]     r1_u  [2];
    logic [U_W-1:0]     r1_u2 [2];
    logic [1:0]         r1_req, r1_quad;
    logic signed [15:0] r1_rot, r1_speed;
    logic               r1_ccw;
    logic [15:0]        hm;
    logic [2*U_W-1:0]   sq [2];
    // stage 2
    logic [U_W-1:0]     r2_u  [2];
    logic [U_W-1:0]     r2_u2 [2];
    logic [TB_W-1:0]    n2_tb [2];
    logic [TB_W-1:0]    r2_tb [2];
    logic [1:0]         r2_req, r2_quad;
    logic signed [15:0] r2_rot, r2_speed;
    logic               r2_ccw;
    logic [C_W+U_W-1:0] pc [2];
    // stage 3
    logic [U_W-1:0]      r3_u  [2];
    logic [TA_W-1:0]     n3_ta [2];
    logic [TA_W-1:0]     r3_ta [2];
    logic [1:0]          r3_req, r3_quad;
    logic signed [15:0]  r3_rot, r3_speed;
    logic                r3_ccw;
    logic [TB_W+U_W-1:0] pb [2];
    // stage 4
    logic [S_W-1:0]      n4_s [2];
    logic [S_W-1:0]      r4_s [2];
    logic [1:0]          r4_req, r4_quad;
    logic signed [15:0]  r4_rot, r4_speed;
    logic                r4_ccw;
    logic [TA_W+U_W-1:0] pa [2];
    // stage 5
    logic signed [V_W-1:0] vx, vy, sp0, sp1;
    logic signed [W_W-1:0] w;
    logic [ROW_EXT_W-1:0]  row_ext [WHEELS];
    logic signed [PW-1:0]  n5_p [WHEELS][3];
    logic signed [PW-1:0]  r5_p [WHEELS][3];
    logic signed [15:0]    r5_speed;
    // stage 6
    logic signed [PW-1:0]  n6_sum [WHEELS];
    logic signed [PW-1:0]  r6_sum [WHEELS];
    logic signed [15:0]    r6_speed;
    // stage 7
    logic signed [VAL_W-1:0] n7_val [WHEELS];
    logic signed [VAL_W-1:0] r7_val [WHEELS];
    // stage 8
    logic [VAL_W-1:0] absv [WHEELS];
    logic [MAG_W-1:0] mag  [WHEELS];
    logic [15:0]      sat  [WHEELS];
    logic [7:0]       duty [WHEELS];
    logic             dirb [WHEELS];
    logic             brk  [WHEELS];
    t_wheel_out       n_out, r_out;

    assign adv         = !(r_vld[7] && i_out_stall);
    assign o_in_stall  = !adv;
    assign o_out_valid = r_vld[7];
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WHEELS; k++) begin
                r_row[k] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(WHEELS))) begin
            r_row[i_cfg_index[ROW_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[6:0], i_in_valid};
        end
    end

    // stage 1: quadrant split and u^2
    always_comb begin
        hm    = i_in_data.heading & HEAD_MASK;
        n1_u[0] = {1'b0, hm[13:0], 2'b00};
        n1_u[1] = U_ONE - n1_u[0];
        for (int l = 0; l < 2; l++) begin
            sq[l]    = (2*U_W)'(n1_u[l]) * (2*U_W)'(n1_u[l]);
            n1_u2[l] = sq[l][U_W+15:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_u     <= n1_u;
            r1_u2    <= n1_u2;
            r1_req   <= i_in_data.req_type;
            r1_quad  <= hm[15:14];
            r1_rot   <= i_in_data.rotation;
            r1_ccw   <= i_in_data.spin_ccw;
            r1_speed <= (i_in_data.req_type == REQ_MOVE || i_in_data.req_type == REQ_SPIN)
                        ? i_in_data.speed : 16'sd0;
        end
    end

    // stage 2: B - C*u^2
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            pc[l]    = (C_W+U_W)'(SIN_C) * (C_W+U_W)'(r1_u2[l]);
            n2_tb[l] = SIN_B - TB_W'(pc[l][C_W+U_W-1:16]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_u     <= r1_u;
            r2_u2    <= r1_u2;
            r2_tb    <= n2_tb;
            r2_req   <= r1_req;
            r2_quad  <= r1_quad;
            r2_rot   <= r1_rot;
            r2_ccw   <= r1_ccw;
            r2_speed <= r1_speed;
        end
    end

    // stage 3: A - tb*u^2
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            pb[l]    = (TB_W+U_W)'(r2_tb[l]) * (TB_W+U_W)'(r2_u2[l]);
            n3_ta[l] = SIN_A - TA_W'(pb[l][TB_W+U_W-1:16]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_u     <= r2_u;
            r3_ta    <= n3_ta;
            r3_req   <= r2_req;
            r3_quad  <= r2_quad;
            r3_rot   <= r2_rot;
            r3_ccw   <= r2_ccw;
            r3_speed <= r2_speed;
        end
    end

    // stage 4: ta*u
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            pa[l]   = (TA_W+U_W)'(r3_ta[l]) * (TA_W+U_W)'(r3_u[l]);
            n4_s[l] = pa[l][S_W+15:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_s     <= n4_s;
            r4_req   <= r3_req;
            r4_quad  <= r3_quad;
            r4_rot   <= r3_rot;
            r4_ccw   <= r3_ccw;
            r4_speed <= r3_speed;
        end
    end

    // stage 5: motion vector and coefficient products
    always_comb begin
        sp0 = V_W'(signed'({1'b0, r4_s[0]}));
        sp1 = V_W'(signed'({1'b0, r4_s[1]}));
        vx  = '0;
        vy  = '0;
        w   = '0;
        unique case (r4_req)
            REQ_MOVE: begin
                case (r4_quad)
                    2'd0: begin
                        vy = sp0;
                        vx = sp1;
                    end
                    2'd1: begin
                        vy = sp1;
                        vx = -sp0;
                    end
                    2'd2: begin
                        vy = -sp0;
                        vx = -sp1;
                    end
                    default: begin
                        vy = -sp1;
                        vx = sp0;
                    end
                endcase
                w = {r4_rot, 2'b00};
            end
            REQ_SPIN: begin
                w = r4_ccw ? W_SPIN_NEG : W_SPIN_POS;
            end
            default: begin
                w = '0;
            end
        endcase
        for (int k = 0; k < WHEELS; k++) begin
            row_ext[k] = ROW_EXT_W'(r_row[k]);
            n5_p[k][0] = PW'(signed'(row_ext[k][0 +: CW])) * PW'(vx);
            n5_p[k][1] = PW'(signed'(row_ext[k][CW +: CW])) * PW'(vy);
            n5_p[k][2] = PW'(signed'(row_ext[k][2*CW +: CW])) * PW'(w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_p     <= n5_p;
            r5_speed <= r4_speed;
        end
    end

    // stage 6: wheel sums
    always_comb begin
        for (int k = 0; k < WHEELS; k++) begin
            n6_sum[k] = r5_p[k][0] + r5_p[k][1] + r5_p[k][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_sum   <= n6_sum;
            r6_speed <= r5_speed;
        end
    end

    // stage 7: speed scale
    always_comb begin
        for (int k = 0; k < WHEELS; k++) begin
            n7_val[k] = VAL_W'(r6_sum[k]) * VAL_W'(r6_speed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_val <= n7_val;
        end
    end

    // stage 8: truncate toward zero, clamp, direction and brake
    always_comb begin
        for (int k = 0; k < WHEELS; k++) begin
            absv[k] = r7_val[k][VAL_W-1] ? VAL_W'(-r7_val[k]) : VAL_W'(r7_val[k]);
            mag[k]  = absv[k][VAL_W-1:SHIFT];
            sat[k]  = (mag[k] > DUTY_LIM) ? DUTY_SAT : 16'(mag[k]);
            duty[k] = sat[k][7:0];
            brk[k]  = (mag[k] == '0);
            dirb[k] = !(r7_val[k][VAL_W-1] && !brk[k]);
        end
        n_out.duty_0  = duty[0];
        n_out.dir_0   = dirb[0];
        n_out.brake_0 = brk[0];
        n_out.duty_1  = duty[1];
        n_out.dir_1   = dirb[1];
        n_out.brake_1 = brk[1];
        n_out.duty_2  = duty[2];
        n_out.dir_2   = dirb[2];
        n_out.brake_2 = brk[2];
        n_out.duty_3  = duty[3];
        n_out.dir_3   = dirb[3];
        n_out.brake_3 = brk[3];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import owvm_pkg::*;

    localparam int COEF_BITS   = 16;
    localparam int FRAC_SHIFT  = 28;
    localparam int DUTY_LIMIT  = 255;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 50;
    localparam int PAUSE_PHASE = 5;
    localparam longint SPIN_ONE = 16384;
    localparam longint POLY_A   = 25736;
    localparam longint POLY_B   = 10512;
    localparam longint POLY_C   = 1160;
    localparam logic [CFG_IDX_W-1:0] LAST_IDX = '1;

    localparam logic [9:0] STOPPED  = {8'd0, 1'b1, 1'b1};
    localparam logic [9:0] FWD_FULL = {8'd255, 1'b1, 1'b0};
    localparam logic [9:0] REV_FULL = {8'd255, 1'b0, 1'b0};

    typedef struct {
        t_cmd       cmd;
        bit         load_first;
        bit         typed;
        t_wheel_out want;
    } t_drill_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    t_cmd             in_data = '0;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0] cfg_data = '0;
    logic             in_stall;
    logic             out_valid;
    t_wheel_out       out_data;
    logic             cfg_ready;

    logic [ROW_W-1:0] mix_row [WHEELS];
    t_wheel_out       pending_wheels [$];
    t_drill_row       drill [$];
    int               mismatch_count = 0;
    int               cycle_count = 0;
    int               tx_gap_pct = 0;
    int               rx_stall_pct = 0;

    omni_wheel_velocity_mixer_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL omni_wheel_velocity_mixer_core");
            $finish;
        end
    end

    // sin(pi/2 * u), u in Q16, result in Q14
    function automatic longint sine_q14(longint unsigned u);
        longint unsigned u2, t;
        u2 = (u * u) >> 16;
        t = (POLY_C * u2) >> 16;
        t = POLY_B - t;
        t = (t * u2) >> 16;
        t = POLY_A - t;
        return longint'((t * u) >> 16);
    endfunction

    function automatic longint coef(int k, int slot);
        return longint'($signed(mix_row[k][slot*COEF_BITS +: COEF_BITS]));
    endfunction

    function automatic t_wheel_out predict_wheels(t_cmd c);
        longint vx, vy, w, spd, sum, val, s_u, s_v;
        longint unsigned u, mag;
        logic [9:0] wh [WHEELS];
        vx = 0;
        vy = 0;
        w = 0;
        spd = longint'(c.speed);
        case (c.req_type)
            REQ_MOVE: begin
                u = {c.heading[13:0], 2'b00};
                s_u = sine_q14(u);
                s_v = sine_q14(65536 - u);
                case (c.heading[15:14])
                    2'd0: begin vy = s_u;  vx = s_v;  end
                    2'd1: begin vy = s_v;  vx = -s_u; end
                    2'd2: begin vy = -s_u; vx = -s_v; end
                    default: begin vy = -s_v; vx = s_u; end
                endcase
                w = longint'(c.rotation) * 4;
            end
            REQ_SPIN: w = c.spin_ccw ? -SPIN_ONE : SPIN_ONE;
            default: spd = 0;
        endcase
        for (int k = 0; k < WHEELS; k++) begin
            sum = coef(k, 0) * vx + coef(k, 1) * vy + coef(k, 2) * w;
            val = sum * spd;
            mag = (val < 0) ? -val : val;
            mag = mag >> FRAC_SHIFT;
            if (mag > DUTY_LIMIT)
                mag = DUTY_LIMIT;
            wh[k] = {mag[7:0], !(val < 0 && mag != 0), mag == 0};
        end
        return t_wheel_out'({wh[0], wh[1], wh[2], wh[3]});
    endfunction

    function automatic logic [9:0] wheel_field(t_wheel_out o, int k);
        case (k)
            0: return {o.duty_0, o.dir_0, o.brake_0};
            1: return {o.duty_1, o.dir_1, o.brake_1};
            2: return {o.duty_2, o.dir_2, o.brake_2};
            default: return {o.duty_3, o.dir_3, o.brake_3};
        endcase
    endfunction

    function automatic void report(string name, int k, int e, int a);
        $display("%0t: wheel %0d %s expected %0d actual %0d", $time, k, name, e, a);
        mismatch_count++;
    endfunction

    function automatic void check_wheels(t_wheel_out got);
        t_wheel_out want;
        logic [9:0] e, a;
        if (pending_wheels.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            mismatch_count++;
            return;
        end
        want = pending_wheels.pop_front();
        for (int k = 0; k < WHEELS; k++) begin
            e = wheel_field(want, k);
            a = wheel_field(got, k);
            if (e[9:2] !== a[9:2]) report("duty", k, e[9:2], a[9:2]);
            if (e[1] !== a[1]) report("dir", k, e[1], a[1]);
            if (e[0] !== a[0]) report("brake", k, e[0], a[0]);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            check_wheels(out_data);
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    function automatic t_cmd make_cmd(logic [1:0] req, logic [15:0] hdg,
                                      logic signed [15:0] rot, logic ccw,
                                      logic signed [15:0] spd);
        t_cmd c;
        c.req_type = req;
        c.heading = hdg;
        c.rotation = rot;
        c.spin_ccw = ccw;
        c.speed = spd;
        return c;
    endfunction

    function automatic void add_drill(t_cmd c, bit load, bit typed, t_wheel_out want);
        t_drill_row r;
        r.cmd = c;
        r.load_first = load;
        r.typed = typed;
        r.want = want;
        drill.push_back(r);
    endfunction

    task automatic push_cmd(t_cmd c, bit typed, t_wheel_out want);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= c;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        pending_wheels.push_back(typed ? want : predict_wheels(c));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_wheels.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        if (idx < WHEELS)
            mix_row[idx[ROW_IDX_W-1:0]] = val;
    endtask

    // writes to unused indexes must leave the rows alone
    task automatic load_rows(logic [ROW_W-1:0] rows [WHEELS], bit stray);
        for (int k = 0; k < WHEELS; k++)
            put_reg(CFG_IDX_W'(k), rows[k]);
        if (stray)
            put_reg(CFG_IDX_W'($urandom_range(WHEELS, LAST_IDX)),
                    {$urandom, 16'($urandom)});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ROW_W-1:0] random_row(int style);
        logic [ROW_W-1:0] r;
        case (style)
            0: r = '0;
            1: r = {3{16'h7FFF}};
            2: r = {3{16'h8000}};
            3: r = '1;
            default: begin
                for (int s = 0; s < 3; s++)
                    r[s*COEF_BITS +: COEF_BITS] = ($urandom_range(0, 9) < 7) ?
                        16'($urandom_range(0, 32768) - 16384) : 16'($urandom);
            end
        endcase
        return r;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int pick;
        c.heading = 16'($urandom);
        c.rotation = 16'($urandom);
        c.spin_ccw = 1'($urandom);
        c.speed = 16'($urandom);
        pick = $urandom_range(0, 99);
        c.req_type = (pick < 55) ? REQ_MOVE : (pick < 80) ? REQ_SPIN :
                     (pick < 95) ? REQ_STOP : 2'($urandom_range(3, 3));
        if ($urandom_range(0, 4) == 0)
            c.heading = 16'({$urandom_range(0, 3), 14'd0} + $urandom_range(0, 2) - 1);
        if ($urandom_range(0, 9) < 7)
            c.rotation = 16'($urandom_range(0, 16383) - 8192);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            c.speed = 16'($urandom_range(0, 800) - 400);
        else if (pick < 75) begin
            case ($urandom_range(0, 4))
                0: c.speed = 16'sh7FFF;
                1: c.speed = 16'sh8000;
                2: c.speed = 16'sd0;
                3: c.speed = 16'sd1;
                default: c.speed = -16'sd1;
            endcase
        end
        return c;
    endfunction

    initial begin
        logic [ROW_W-1:0] rows [WHEELS];
        for (int k = 0; k < WHEELS; k++)
            mix_row[k] = '0;

        // zero matrix after reset: every wheel stopped
        add_drill(make_cmd(REQ_MOVE, 16'h0000, 16'sh7FFF, 1'b0, 16'sh7FFF), 1'b0, 1'b1,
                  t_wheel_out'({4{STOPPED}}));
        add_drill(make_cmd(REQ_SPIN, 16'h0000, 16'sd0, 1'b0, 16'sh8000), 1'b0, 1'b1,
                  t_wheel_out'({4{STOPPED}}));
        add_drill(make_cmd(REQ_STOP, 16'hFFFF, -16'sd1, 1'b1, 16'sh7FFF), 1'b0, 1'b1,
                  t_wheel_out'({4{STOPPED}}));
        // saturation at full speed, spin uses the rotation column only
        add_drill(make_cmd(REQ_SPIN, 16'h0000, 16'sd0, 1'b0, 16'sh7FFF), 1'b1, 1'b1,
                  t_wheel_out'({FWD_FULL, FWD_FULL, REV_FULL, FWD_FULL}));
        add_drill(make_cmd(REQ_SPIN, 16'h0000, 16'sd0, 1'b1, 16'sh7FFF), 1'b0, 1'b1,
                  t_wheel_out'({REV_FULL, REV_FULL, FWD_FULL, REV_FULL}));
        add_drill(make_cmd(REQ_SPIN, 16'hFFFF, 16'sh8000, 1'b0, 16'sh8000), 1'b0, 1'b1,
                  t_wheel_out'({REV_FULL, REV_FULL, FWD_FULL, REV_FULL}));
        add_drill(make_cmd(REQ_STOP, 16'h1234, 16'sh7FFF, 1'b0, 16'sh8000), 1'b0, 1'b1,
                  t_wheel_out'({4{STOPPED}}));
        add_drill(make_cmd(2'($urandom_range(3, 3)), 16'hFFFF, 16'sh8000, 1'b1, 16'sh7FFF),
                  1'b0, 1'b1, t_wheel_out'({4{STOPPED}}));
        add_drill(make_cmd(REQ_MOVE, 16'h0000, 16'sd0, 1'b0, 16'sd100), 1'b0, 1'b0, '0);
        add_drill(make_cmd(REQ_MOVE, 16'h4000, 16'sd0, 1'b0, 16'sd100), 1'b0, 1'b0, '0);
        add_drill(make_cmd(REQ_MOVE, 16'h8000, 16'sd0, 1'b0, 16'sd100), 1'b0, 1'b0, '0);
        add_drill(make_cmd(REQ_MOVE, 16'hC000, 16'sd0, 1'b0, 16'sd100), 1'b0, 1'b0, '0);
        add_drill(make_cmd(REQ_MOVE, 16'hFFFF, 16'sh8000, 1'b0, 16'sh8000), 1'b0, 1'b0, '0);
        add_drill(make_cmd(REQ_MOVE, 16'h3FFF, 16'sh7FFF, 1'b0, 16'sd1), 1'b0, 1'b0, '0);
        add_drill(make_cmd(REQ_MOVE, 16'h2000, 16'sd4096, 1'b0, 16'sd255), 1'b0, 1'b0, '0);
        // small negative value truncates to zero: forward, braked
        add_drill(make_cmd(REQ_MOVE, 16'h4000, -16'sd1, 1'b0, 16'sd1), 1'b0, 1'b0, '0);
        add_drill(make_cmd(REQ_SPIN, 16'h0000, 16'sd0, 1'b0, 16'sd1), 1'b0, 1'b0, '0);
        add_drill(make_cmd(REQ_SPIN, 16'h0000, 16'sd0, 1'b1, -16'sd1), 1'b0, 1'b0, '0);
        add_drill(make_cmd(REQ_SPIN, 16'h0000, 16'sd0, 1'b0, 16'sd0), 1'b0, 1'b0, '0);
        add_drill(make_cmd(REQ_MOVE, 16'h6000, 16'h1234, 1'b1, -16'sd200), 1'b0, 1'b0, '0);
        add_drill(make_cmd(REQ_SPIN, 16'hFFFF, 16'sh8000, 1'b0, 16'sd300), 1'b0, 1'b0, '0);
        add_drill(make_cmd(REQ_MOVE, 16'h1555, 16'sd0, 1'b0, 16'sh7FFF), 1'b0, 1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (drill[i]) begin
            if (drill[i].load_first) begin
                settle();
                rows[0] = {16'h4000, 16'h0000, 16'h4000};
                rows[1] = {16'h4000, 16'h4000, 16'h0000};
                rows[2] = {16'h8000, 16'hC000, 16'h7FFF};
                rows[3] = {16'h7FFF, 16'h8000, 16'hC000};
                load_rows(rows, 1'b1);
            end
            push_cmd(drill[i].cmd, drill[i].typed, drill[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            tx_gap_pct = 0;
            rx_stall_pct = 0;
            for (int k = 0; k < WHEELS; k++)
                rows[k] = random_row(p);
            load_rows(rows, p[0]);
            case (p % 4)
                1: tx_gap_pct = 46;
                2: rx_stall_pct = 46;
                3: begin tx_gap_pct = 9; rx_stall_pct = 9; end
                default: ;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2)
                    settle();
                push_cmd(random_cmd(), 1'b0, '0);
            end
        end

        settle();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS omni_wheel_velocity_mixer_core");
        else
            $display("FAIL omni_wheel_velocity_mixer_core");
        $finish;
    end

endmodule

// ===== omni_wheel_velocity_mixer_core.f =====
src/owvm_pkg.sv
src/omni_wheel_velocity_mixer_core.sv
sim/testbench.sv
